// File: rtl/core/lcps_pkg.sv
// ----------------------------------------------------------------------------
// lcps_pkg
// Shared types, codes and constants of the light chase pattern sequencer.
// ----------------------------------------------------------------------------
package lcps_pkg;

    // default light count
    localparam int NUM_LIGHTS_DEF = 2;

    // register field widths
    localparam int HOLD_W  = 16;
    localparam int BLINK_W = 16;
    localparam int ACCEL_W = 8;
    localparam int TICK_W  = 32;
    localparam int PHASE_W = 3;

    // modulo unit widths: the divisor is wide enough for either period
    localparam int DIV_NUM_W = TICK_W;
    localparam int DIV_DEN_W = BLINK_W;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_PERIOD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_START  = 2'd2;

    // register reset values
    localparam logic [HOLD_W-1:0]  HOLD_RST  = 16'd100;
    localparam logic [BLINK_W-1:0] BLINK_RST = 16'd10;
    localparam logic [ACCEL_W-1:0] ACCEL_RST = 8'd20;

    // animation phases, the two remaining codes are never entered
    typedef enum logic [PHASE_W-1:0] {
        PH_ALL_ON    = 3'd0,
        PH_SINGLE    = 3'd1,
        PH_PARITY    = 3'd2,
        PH_CHASE     = 3'd3,
        PH_CHASE_OFF = 3'd4,
        PH_INSIDE    = 3'd5
    } t_phase;

    // configuration register values
    typedef struct packed {
        logic [HOLD_W-1:0]  hold_ticks;
        logic [BLINK_W-1:0] blink_period;
        logic [ACCEL_W-1:0] accel_start;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic load_run;
        logic div_start;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_mod;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

// File: rtl/core/led_chase_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// led_chase_pattern_sequencer
// Six-phase light animation, one result per tick transaction.
// A tick passes plan, an optional modulo and commit before its result is valid.
// One tick at a time; the 32-step modulo unit and a full output register delay the next.
// A finished result waits in the output register while the next tick is taken.
// Reset (synchronous, active low): registers to 100/10/20, phase all-on, idle.
// ----------------------------------------------------------------------------
module led_chase_pattern_sequencer #(
    parameter int NUM_LIGHTS = lcps_pkg::NUM_LIGHTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input ticks
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [0] run
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((NUM_LIGHTS + lcps_pkg::PHASE_W + 7) / 8) * 8 - 1:0]
                                                m_axis_tdata,   // lights, phase
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lcps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lcps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int OUT_W = ((NUM_LIGHTS + lcps_pkg::PHASE_W + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - NUM_LIGHTS - lcps_pkg::PHASE_W;

    lcps_pkg::t_cfg    r_cfg;
    lcps_pkg::t_cmd    cmd;
    lcps_pkg::t_status status;
    logic [lcps_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;
    logic [NUM_LIGHTS-1:0]          lights;
    logic [lcps_pkg::PHASE_W-1:0]   phase;

    assign reg_idx = paddr[lcps_pkg::REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks   <= lcps_pkg::HOLD_RST;
            r_cfg.blink_period <= lcps_pkg::BLINK_RST;
            r_cfg.accel_start  <= lcps_pkg::ACCEL_RST;
        end else if (wr_en) begin
            case (reg_idx)
                lcps_pkg::REG_HOLD_TICKS:   r_cfg.hold_ticks   <= pwdata[lcps_pkg::HOLD_W-1:0];
                lcps_pkg::REG_BLINK_PERIOD: r_cfg.blink_period <= pwdata[lcps_pkg::BLINK_W-1:0];
                lcps_pkg::REG_ACCEL_START:  r_cfg.accel_start  <= pwdata[lcps_pkg::ACCEL_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            lcps_pkg::REG_HOLD_TICKS:
                prdata = lcps_pkg::APB_DATA_W'(r_cfg.hold_ticks);
            lcps_pkg::REG_BLINK_PERIOD:
                prdata = lcps_pkg::APB_DATA_W'(r_cfg.blink_period);
            lcps_pkg::REG_ACCEL_START:
                prdata = lcps_pkg::APB_DATA_W'(r_cfg.accel_start);
            default:
                prdata = '0;
        endcase
    end

    // tick sequencer
    lcps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // state, patterns and result register
    lcps_datapath #(
        .NUM_LIGHTS (NUM_LIGHTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .i_run       (s_axis_tdata[0]),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_lights    (lights),
        .o_phase     (phase)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, phase, lights};

    // one tick at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("tick accepted while the previous one is in flight");

    // modulo only started when a step needs it and it is idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> (status.need_mod && !status.div_busy))
        else $error("modulo started without need or while busy");

    // a commit never overwrites a waiting result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten before it was taken");

    // commit only after the modulo has finished
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !status.div_busy)
        else $error("commit while modulo in progress");

endmodule

// File: rtl/core/lcps_mod_unit.sv
// ----------------------------------------------------------------------------
// lcps_mod_unit
// Restoring modulo unit, one dividend bit per cycle, reports a zero remainder.
// ----------------------------------------------------------------------------
module lcps_mod_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [lcps_pkg::DIV_NUM_W-1:0]     i_dividend,
    input  logic [lcps_pkg::DIV_DEN_W-1:0]     i_divisor,
    output logic                               o_busy,
    output logic                               o_zero
);

    localparam int NUM_W = lcps_pkg::DIV_NUM_W;
    localparam int DEN_W = lcps_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W-1:0] r_den, n_den;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [DEN_W:0]   trial;

    // one shift and trial subtract per cycle
    always_comb begin
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        trial  = {r_rem, r_num[NUM_W-1]};
        if (i_start) begin
            n_num  = i_dividend;
            n_den  = i_divisor;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DEN_W'(trial - {1'b0, r_den});
            end else begin
                n_rem = trial[DEN_W-1:0];
            end
            n_num = {r_num[NUM_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_busy = r_busy;
    assign o_zero = (r_rem == '0);

endmodule

// File: rtl/core/lcps_datapath.sv
// ----------------------------------------------------------------------------
// lcps_datapath
// Animation state, pattern generation and the result register.
// ----------------------------------------------------------------------------
module lcps_datapath #(
    parameter int NUM_LIGHTS = lcps_pkg::NUM_LIGHTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lcps_pkg::t_cmd                  i_cmd,
    input  lcps_pkg::t_cfg                  i_cfg,
    input  logic                            i_run,
    input  logic                            i_out_ready,
    output lcps_pkg::t_status               o_status,
    output logic                            o_out_valid,
    output logic [NUM_LIGHTS-1:0]           o_lights,
    output logic [lcps_pkg::PHASE_W-1:0]    o_phase
);

    localparam int LOG_N = $clog2(NUM_LIGHTS);
    // r_pos also holds the value two in the parity phase
    localparam int POS_W = (LOG_N < 2) ? 2 : LOG_N;
    localparam int TICK_W = lcps_pkg::TICK_W;
    localparam int ACCEL_W = lcps_pkg::ACCEL_W;
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(NUM_LIGHTS - 1);
    localparam logic [POS_W-1:0] HALF_POS   = POS_W'(NUM_LIGHTS / 2);
    localparam logic [POS_W-1:0] INNER_LAST = POS_W'(NUM_LIGHTS / 2 - 1);
    localparam logic [POS_W-1:0] PARITY_END = POS_W'(2);

    lcps_pkg::t_phase       r_phase, n_phase;
    logic [TICK_W-1:0]      r_tick, n_tick;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic                   r_level, n_level;
    logic [ACCEL_W-1:0]     r_ival, n_ival;
    logic                   r_run;
    logic                   r_out_valid, n_out_valid;
    logic [NUM_LIGHTS-1:0]  r_out_lights;
    logic [lcps_pkg::PHASE_W-1:0] r_out_phase;

    logic [NUM_LIGHTS-1:0]  lights;
    logic [lcps_pkg::PHASE_W-1:0] shown;
    logic                   is_chase;
    logic                   below_hold;
    logic                   need_mod;
    logic [TICK_W-1:0]      tick_inc;
    logic [POS_W-1:0]       mirror;
    logic [lcps_pkg::DIV_DEN_W-1:0] divisor;
    logic                   div_busy;
    logic                   div_zero;

    assign tick_inc   = r_tick + 1'b1;
    assign below_hold = (r_tick < {{(TICK_W - lcps_pkg::HOLD_W){1'b0}}, i_cfg.hold_ticks});
    assign is_chase   = r_phase inside {lcps_pkg::PH_CHASE, lcps_pkg::PH_CHASE_OFF,
                                        lcps_pkg::PH_INSIDE};
    assign divisor    = is_chase ?
                        {{(lcps_pkg::DIV_DEN_W - ACCEL_W){1'b0}}, r_ival} :
                        i_cfg.blink_period;
    assign mirror     = LAST_POS - r_pos;

    // a modulo is needed by the blink toggle and by the chase step
    always_comb begin
        need_mod = 1'b0;
        if (r_run) begin
            case (r_phase)
                lcps_pkg::PH_SINGLE,
                lcps_pkg::PH_PARITY:    need_mod = below_hold &&
                                                   (i_cfg.blink_period != '0);
                lcps_pkg::PH_CHASE,
                lcps_pkg::PH_CHASE_OFF,
                lcps_pkg::PH_INSIDE:    need_mod = (r_ival != '0);
                default:                need_mod = 1'b0;
            endcase
        end
    end

    // tick-count modulo unit
    lcps_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (tick_inc),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_zero     (div_zero)
    );

    // light pattern from the current state
    always_comb begin
        lights = '0;
        shown  = '0;
        if (r_run) begin
            shown = r_phase;
            for (int i = 0; i < NUM_LIGHTS; i++) begin
                case (r_phase)
                    lcps_pkg::PH_ALL_ON:    lights[i] = 1'b1;
                    lcps_pkg::PH_SINGLE:    lights[i] = (POS_W'(i) == r_pos) ? r_level : 1'b1;
                    lcps_pkg::PH_PARITY:    lights[i] = (POS_W'(i % 2) == r_pos) ?
                                                        r_level : 1'b1;
                    lcps_pkg::PH_CHASE:     lights[i] = (POS_W'(i) != r_pos);
                    lcps_pkg::PH_CHASE_OFF: lights[i] = (POS_W'(i) == r_pos);
                    lcps_pkg::PH_INSIDE:    lights[i] = (r_pos < HALF_POS) &&
                                                        ((POS_W'(i) == r_pos) ||
                                                         (POS_W'(i) == mirror));
                    default:                lights[i] = 1'b0;
                endcase
            end
        end
    end

    // state update on commit
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_pos   = r_pos;
        n_level = r_level;
        n_ival  = r_ival;
        if (i_cmd.commit) begin
            if (!r_run) begin
                n_phase = lcps_pkg::PH_ALL_ON;
                n_tick  = '0;
                n_pos   = '0;
                n_level = 1'b0;
                n_ival  = i_cfg.accel_start;
            end else begin
                case (r_phase)
                    lcps_pkg::PH_ALL_ON: begin
                        if (below_hold) begin
                            n_tick = tick_inc;
                        end else begin
                            n_tick  = '0;
                            n_level = 1'b0;
                            n_phase = lcps_pkg::PH_SINGLE;
                        end
                    end
                    lcps_pkg::PH_SINGLE,
                    lcps_pkg::PH_PARITY: begin
                        if (below_hold) begin
                            n_tick = tick_inc;
                            if (need_mod && div_zero) begin
                                n_level = ~r_level;
                            end
                        end else begin
                            n_tick  = '0;
                            n_level = 1'b0;
                            if (r_pos < ((r_phase == lcps_pkg::PH_SINGLE) ?
                                         LAST_POS : PARITY_END)) begin
                                n_pos = r_pos + 1'b1;
                            end else begin
                                n_pos   = '0;
                                n_phase = (r_phase == lcps_pkg::PH_SINGLE) ?
                                          lcps_pkg::PH_PARITY : lcps_pkg::PH_CHASE;
                            end
                        end
                    end
                    lcps_pkg::PH_CHASE,
                    lcps_pkg::PH_CHASE_OFF,
                    lcps_pkg::PH_INSIDE: begin
                        if (r_ival != '0) begin
                            n_tick = tick_inc;
                            if (div_zero) begin
                                if (r_pos < ((r_phase == lcps_pkg::PH_INSIDE) ?
                                             INNER_LAST : LAST_POS)) begin
                                    n_pos = r_pos + 1'b1;
                                end else begin
                                    n_pos  = '0;
                                    n_ival = r_ival - 1'b1;
                                end
                            end
                        end else begin
                            n_tick  = '0;
                            n_pos   = '0;
                            n_level = 1'b0;
                            n_ival  = i_cfg.accel_start;
                            case (r_phase)
                                lcps_pkg::PH_CHASE:     n_phase = lcps_pkg::PH_CHASE_OFF;
                                lcps_pkg::PH_CHASE_OFF: n_phase = lcps_pkg::PH_INSIDE;
                                default:                n_phase = lcps_pkg::PH_ALL_ON;
                            endcase
                        end
                    end
                    default: begin
                        n_phase = lcps_pkg::PH_ALL_ON;
                        n_tick  = '0;
                        n_pos   = '0;
                        n_level = 1'b0;
                        n_ival  = i_cfg.accel_start;
                    end
                endcase
            end
        end
    end

    // result register handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lcps_pkg::PH_ALL_ON;
            r_tick      <= '0;
            r_pos       <= '0;
            r_level     <= 1'b0;
            r_ival      <= lcps_pkg::ACCEL_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_pos       <= n_pos;
            r_level     <= n_level;
            r_ival      <= n_ival;
            r_out_valid <= n_out_valid;
        end
        if (i_cmd.load_run) begin
            r_run <= i_run;
        end
        if (i_cmd.commit) begin
            r_out_lights <= lights;
            r_out_phase  <= shown;
        end
    end

    assign o_status.need_mod = need_mod;
    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_lights          = r_out_lights;
    assign o_phase           = r_out_phase;

endmodule

// File: rtl/core/lcps_ctrl.sv
// ----------------------------------------------------------------------------
// lcps_ctrl
// Sequencer for one tick: take the transaction, run the modulo when needed, commit.
// ----------------------------------------------------------------------------
module lcps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  lcps_pkg::t_status   i_status,
    output logic                o_in_ready,
    output lcps_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PLAN   = 4'b0010,
        S_DIV    = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.load_run  = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_run = 1'b1;
                    n_state        = S_PLAN;
                end
            end
            S_PLAN: begin
                if (i_status.need_mod) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the light chase sequencer end to end against a cycle-free predictor:
// ticks stream in through the slave port, every result frame is compared
// field by field with the predicted one, and the registers are reprogrammed
// over apb between phases of directed and random traffic with random stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NL         = lcps_pkg::NUM_LIGHTS_DEF;
    localparam int OUT_W      = ((NL + lcps_pkg::PHASE_W + 7) / 8) * 8;
    localparam int SETTLE     = 40;
    localparam int HOLD_OFF   = 400;
    localparam int LIMIT      = 1000000;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_LEN  = 88;

    // one expected result frame
    typedef struct {
        logic [NL-1:0]    lights;
        lcps_pkg::t_phase phase;
    } t_frame;

    // predictor and store of expected frames
    class chase_scoreboard;
        logic [lcps_pkg::HOLD_W-1:0]  hold_ticks;
        logic [lcps_pkg::BLINK_W-1:0] blink_period;
        logic [lcps_pkg::ACCEL_W-1:0] accel_start;

        lcps_pkg::t_phase             phase_now;
        logic [lcps_pkg::TICK_W-1:0]  ticks;
        logic [1:0]                   pos;
        logic                         level;
        logic [lcps_pkg::ACCEL_W-1:0] interval;

        t_frame             want_q[$];
        int                 fails;

        function new();
            hold_ticks   = lcps_pkg::HOLD_RST;
            blink_period = lcps_pkg::BLINK_RST;
            accel_start  = lcps_pkg::ACCEL_RST;
            phase_now    = lcps_pkg::PH_ALL_ON;
            fails        = 0;
            clear_counters();
        endfunction

        function void clear_counters();
            ticks    = '0;
            level    = 1'b0;
            interval = accel_start;
            pos      = '0;
        endfunction

        function void set_reg(logic [lcps_pkg::REG_IDX_W-1:0] idx,
                              logic [lcps_pkg::APB_DATA_W-1:0] value);
            case (idx)
                lcps_pkg::REG_HOLD_TICKS:   hold_ticks   = value[lcps_pkg::HOLD_W-1:0];
                lcps_pkg::REG_BLINK_PERIOD: blink_period = value[lcps_pkg::BLINK_W-1:0];
                lcps_pkg::REG_ACCEL_START:  accel_start  = value[lcps_pkg::ACCEL_W-1:0];
                default: ;
            endcase
        endfunction

        // light at pos follows lvl, all others show rest
        function logic [NL-1:0] one_differs(logic [1:0] p, logic lvl, logic rest);
            logic [NL-1:0] m;
            m = '0;
            for (int i = 0; i < NL; i++)
                m[i] = (i == p) ? lvl : rest;
            return m;
        endfunction

        function logic [NL-1:0] parity_lights(logic [1:0] p, logic lvl);
            logic [NL-1:0] m;
            m = '0;
            for (int i = 0; i < NL; i++)
                m[i] = ((i & 1) == p) ? lvl : 1'b1;
            return m;
        endfunction

        // mirrored pair, the middle light of an odd count stays dark
        function logic [NL-1:0] inside_lights(logic [1:0] p);
            logic [NL-1:0] m;
            m = '0;
            if (p < NL / 2) begin
                m[p]          = 1'b1;
                m[NL - 1 - p] = 1'b1;
            end
            return m;
        endfunction

        // steady or blink step, true when the step is over
        function bit steady_step(bit toggles);
            if (ticks < hold_ticks) begin
                ticks++;
                if (toggles && blink_period != 0 && (ticks % blink_period) == 0)
                    level = ~level;
                return 1'b0;
            end
            ticks = '0;
            level = 1'b0;
            return 1'b1;
        endfunction

        // chase step, true when the chase phase is over
        function bit chase_step(int last_pos);
            if (interval > 0) begin
                ticks++;
                if ((ticks % interval) == 0) begin
                    if (pos < last_pos) begin
                        pos++;
                    end else begin
                        pos = '0;
                        interval--;
                    end
                end
                return 1'b0;
            end
            clear_counters();
            return 1'b1;
        endfunction

        // predict the frame of one accepted tick
        function void add_tick(bit run);
            t_frame f;
            f.lights = '0;
            f.phase  = lcps_pkg::PH_ALL_ON;
            if (!run) begin
                clear_counters();
                phase_now = lcps_pkg::PH_ALL_ON;
            end else begin
                f.phase = phase_now;
                case (phase_now)
                    lcps_pkg::PH_ALL_ON: begin
                        f.lights = '1;
                        if (steady_step(1'b0))
                            phase_now = lcps_pkg::PH_SINGLE;
                    end
                    lcps_pkg::PH_SINGLE: begin
                        f.lights = one_differs(pos, level, 1'b1);
                        if (steady_step(1'b1)) begin
                            if (pos < NL - 1) begin
                                pos++;
                            end else begin
                                pos       = '0;
                                phase_now = lcps_pkg::PH_PARITY;
                            end
                        end
                    end
                    lcps_pkg::PH_PARITY: begin
                        f.lights = parity_lights(pos, level);
                        if (steady_step(1'b1)) begin
                            if (pos < 2) begin
                                pos++;
                            end else begin
                                pos       = '0;
                                phase_now = lcps_pkg::PH_CHASE;
                            end
                        end
                    end
                    lcps_pkg::PH_CHASE: begin
                        f.lights = one_differs(pos, 1'b0, 1'b1);
                        if (chase_step(NL - 1))
                            phase_now = lcps_pkg::PH_CHASE_OFF;
                    end
                    lcps_pkg::PH_CHASE_OFF: begin
                        f.lights = one_differs(pos, 1'b1, 1'b0);
                        if (chase_step(NL - 1))
                            phase_now = lcps_pkg::PH_INSIDE;
                    end
                    lcps_pkg::PH_INSIDE: begin
                        f.lights = inside_lights(pos);
                        if (chase_step(NL / 2 - 1))
                            phase_now = lcps_pkg::PH_ALL_ON;
                    end
                    default: begin
                        f.lights = '0;
                        clear_counters();
                        phase_now = lcps_pkg::PH_ALL_ON;
                    end
                endcase
            end
            want_q.push_back(f);
        endfunction

        // compare one accepted result frame with the oldest prediction
        function void match_result(logic [OUT_W-1:0] data);
            t_frame f;
            if (want_q.size() == 0) begin
                $error("unexpected result transaction: tdata %0h", data);
                fails++;
                return;
            end
            f = want_q.pop_front();
            if (data[NL-1:0] !== f.lights) begin
                $error("lights: expected %0h, actual %0h", f.lights, data[NL-1:0]);
                fails++;
            end
            if (data[NL +: lcps_pkg::PHASE_W] !== f.phase) begin
                $error("phase: expected %0d, actual %0d", f.phase,
                       data[NL +: lcps_pkg::PHASE_W]);
                fails++;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;    // [0] run
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [OUT_W-1:0]                m_axis_tdata;    // [1:0] lights, [4:2] phase
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lcps_pkg::APB_ADDR_W-1:0] paddr;
    logic [lcps_pkg::APB_DATA_W-1:0] pwdata;
    logic [lcps_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    chase_scoreboard sb;
    bit              steady_mode;
    int              hold_off_cycles;

    led_chase_pattern_sequencer #(.NUM_LIGHTS(NL)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result sink: random stalls or always ready in steady mode, a long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles - 1) @(negedge i_clk);
                hold_off_cycles = 0;
            end else begin
                m_axis_tready <= steady_mode ? 1'b1 : ($urandom_range(99) >= 25);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.match_result(m_axis_tdata);
    end

    // watchdog
    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // offer one tick and wait for its transaction
    task automatic send_tick(input bit run);
        if (!steady_mode) begin
            while ($urandom_range(99) < 25) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, run};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.add_tick(run);
    endtask

    // stop offering and let every expected result come out
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [lcps_pkg::REG_IDX_W-1:0] idx,
                              input logic [lcps_pkg::APB_DATA_W-1:0] wdata,
                              output logic [lcps_pkg::APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write one register and read it back
    task automatic program_reg(input logic [lcps_pkg::REG_IDX_W-1:0] idx,
                               input int unsigned value, input int unsigned mask);
        logic [lcps_pkg::APB_DATA_W-1:0] rd;
        apb_access(1'b1, idx, value & mask, rd);
        sb.set_reg(idx, value & mask);
        apb_access(1'b0, idx, '0, rd);
        if (rd !== (value & mask)) begin
            $error("register %0d: expected %0h, actual %0h", idx, value & mask, rd);
            sb.fails++;
        end
    endtask

    task automatic program_all(input int unsigned hold, input int unsigned blink,
                               input int unsigned accel);
        program_reg(lcps_pkg::REG_HOLD_TICKS, hold, 32'hFFFF);
        program_reg(lcps_pkg::REG_BLINK_PERIOD, blink, 32'hFFFF);
        program_reg(lcps_pkg::REG_ACCEL_START, accel, 32'hFF);
    endtask

    initial begin
        int unsigned burst;
        sb              = new();
        steady_mode     = 1'b0;
        hold_off_cycles = 0;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values, start with a stopped tick
        send_tick(1'b0);
        send_tick(1'b1);
        drain_results();

        // all zero: one-tick steps, no blink, chase phases end at once
        program_all(0, 0, 0);
        send_tick(1'b0);
        repeat (10) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_results();

        // smallest nonzero settings through the single and parity phases
        program_all(1, 1, 1);
        repeat (10) send_tick(1'b1);
        drain_results();

        // random phases over a series of settings
        for (int s = 0; s < NUM_PHASES; s++) begin
            drain_results();
            case (s)
                2:       program_all(16'hFFFF, 16'hFFFF, 8'hFF);
                5:       program_all(1, 1, 1);
                7:       program_all($urandom_range(65535), $urandom_range(65535),
                                     $urandom_range(255));
                default: program_all($urandom_range(6), $urandom_range(4),
                                     $urandom_range(4));
            endcase
            steady_mode = (s == 4);
            if (s == 3)
                hold_off_cycles = HOLD_OFF;
            if ((s % 4) != 1)
                send_tick(1'b0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                // mostly running ticks, some stops and short stop bursts
                if ($urandom_range(99) < 3) begin
                    burst = $urandom_range(5, 2);
                    repeat (burst) send_tick(1'b0);
                    n += burst - 1;
                end else begin
                    send_tick($urandom_range(99) >= 5);
                end
            end
        end
        steady_mode = 1'b0;
        drain_results();

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: led_chase_pattern_sequencer.f
rtl/core/lcps_pkg.sv
rtl/core/lcps_mod_unit.sv
rtl/core/lcps_datapath.sv
rtl/core/lcps_ctrl.sv
rtl/core/led_chase_pattern_sequencer.sv
verif/tb.sv
